>>> hw/rtl/sfr_pkg.sv
// sfr_pkg: shared types and constants of the stuffed frame receiver
// no dependencies
`default_nettype none

package sfr_pkg;

   localparam int MAX_BYTES = 2048;
   localparam int CNT_W     = $clog2(MAX_BYTES + 2);
   localparam int LEN_W     = 12;
   localparam int CSR_IDX_W = 3;
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_FLAG    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL0   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL1   = 3'd5;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_ACCEPT  = 2'd1;
   localparam logic [1:0] KIND_REJECT  = 2'd2;
   localparam logic [1:0] KIND_LONG    = 2'd3;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       payload_byte;
      logic             frame_seq;
      logic [LEN_W-1:0] payload_length;
   } sfr_result_type;

endpackage

`default_nettype wire

>>> hw/rtl/sfr_front.sv
// sfr_front: csr registers, frame parser, destuffer and result classifier
// depends on sfr_pkg
`default_nettype none

module sfr_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             byte_valid,
   input  wire logic [7:0]                       byte_data,
   input  wire logic                             csr_we,
   input  wire logic [sfr_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  wire logic [7:0]                       csr_wdata,
   output logic                                  res_valid,
   output sfr_pkg::sfr_result_type               res
);

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_ADDR = 3'd1;
   localparam logic [2:0] PH_CTRL = 3'd2;
   localparam logic [2:0] PH_HCHK = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_ESC  = 3'd5;

   localparam int CW = sfr_pkg::CNT_W;
   localparam int LW = sfr_pkg::LEN_W;

   logic [7:0]    flag_ff, escape_ff, mask_ff, address_ff, ctrl0_ff, ctrl1_ff;
   logic [2:0]    phase_ff, phase_in;
   logic          seq_ff, seq_in;
   logic [7:0]    held_ff, held_in;
   logic          held_valid_ff, held_valid_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    xor_ff, xor_in;

   logic [7:0]    cur_ctrl;
   logic [7:0]    data_byte;
   logic          take;
   logic [CW-1:0] len_full;
   logic [CW+LW-1:0] len_wide;

   assign cur_ctrl  = seq_ff ? ctrl1_ff : ctrl0_ff;
   assign data_byte = (phase_ff == PH_ESC) ? (byte_data ^ mask_ff) : byte_data;
   assign len_full  = (count_ff != '0) ? count_ff - CW'(1) : '0;
   assign len_wide  = {{LW{1'b0}}, len_full};

   always_comb begin
      phase_in      = phase_ff;
      seq_in        = seq_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      count_in      = count_ff;
      xor_in        = xor_ff;
      take          = 1'b0;
      res_valid     = 1'b0;
      res.kind           = sfr_pkg::KIND_PAYLOAD;
      res.payload_byte   = '0;
      res.frame_seq      = seq_ff;
      res.payload_length = '0;
      if (byte_valid) begin
         case (phase_ff)
            PH_HUNT: begin
               if (byte_data == flag_ff) phase_in = PH_ADDR;
            end
            PH_ADDR: begin
               if (byte_data == address_ff) phase_in = PH_CTRL;
               else if (byte_data != flag_ff) phase_in = PH_HUNT;
            end
            PH_CTRL: begin
               phase_in = (byte_data == cur_ctrl) ? PH_HCHK : PH_HUNT;
            end
            PH_HCHK: begin
               if (byte_data == (address_ff ^ cur_ctrl)) begin
                  phase_in      = PH_DATA;
                  held_valid_in = 1'b0;
                  count_in      = '0;
                  xor_in        = '0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_DATA: begin
               if (byte_data == flag_ff) begin
                  res_valid          = 1'b1;
                  res.payload_length = len_wide[LW-1:0];
                  if (count_ff != '0 && xor_ff == 8'd0) begin
                     res.kind = sfr_pkg::KIND_ACCEPT;
                     seq_in   = ~seq_ff;
                  end else begin
                     res.kind = sfr_pkg::KIND_REJECT;
                  end
                  held_valid_in = 1'b0;
                  phase_in      = PH_HUNT;
               end else if (byte_data == escape_ff) begin
                  phase_in = PH_ESC;
               end else begin
                  take = 1'b1;
               end
            end
            PH_ESC: begin
               phase_in = PH_DATA;
               take     = 1'b1;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
         if (take) begin
            if (count_ff >= CW'(sfr_pkg::MAX_BYTES + 1)) begin
               res_valid     = 1'b1;
               res.kind      = sfr_pkg::KIND_LONG;
               phase_in      = PH_HUNT;
               held_valid_in = 1'b0;
            end else begin
               if (held_valid_ff) begin
                  res_valid        = 1'b1;
                  res.payload_byte = held_ff;
               end
               held_in       = data_byte;
               held_valid_in = 1'b1;
               count_in      = count_ff + CW'(1);
               xor_in        = xor_ff ^ data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         seq_ff        <= 1'b0;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
         xor_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         seq_ff        <= seq_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
         xor_ff        <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff    <= 8'd126;
         escape_ff  <= 8'd125;
         mask_ff    <= 8'd32;
         address_ff <= 8'd3;
         ctrl0_ff   <= 8'd0;
         ctrl1_ff   <= 8'd128;
      end else if (csr_we) begin
         case (csr_idx)
            sfr_pkg::CSR_FLAG:    flag_ff    <= csr_wdata;
            sfr_pkg::CSR_ESCAPE:  escape_ff  <= csr_wdata;
            sfr_pkg::CSR_MASK:    mask_ff    <= csr_wdata;
            sfr_pkg::CSR_ADDRESS: address_ff <= csr_wdata;
            sfr_pkg::CSR_CTRL0:   ctrl0_ff   <= csr_wdata;
            sfr_pkg::CSR_CTRL1:   ctrl1_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/sfr_queue.sv
// sfr_queue: short result queue between the parser and the output stage
// depends on sfr_pkg
`default_nettype none

module sfr_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire sfr_pkg::sfr_result_type push_data,
   input  wire logic                    pop,
   output logic                         full,
   output logic                         head_valid,
   output sfr_pkg::sfr_result_type      head_data
);

   localparam int PW = sfr_pkg::Q_PTR_W;
   localparam int NW = sfr_pkg::Q_CNT_W;

   sfr_pkg::sfr_result_type mem_ff [sfr_pkg::Q_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [NW-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == NW'(sfr_pkg::Q_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + PW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PW'(1) : rd_ff;
      cnt_in = cnt_ff + NW'(push) - NW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

`default_nettype wire

>>> hw/rtl/sfr_back.sv
// sfr_back: output register that drains the result queue under rsp stall
// depends on sfr_pkg
`default_nettype none

module sfr_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  wire sfr_pkg::sfr_result_type head_data,
   output logic                         pop,
   input  wire logic                    out_stall,
   output logic                         out_valid,
   output sfr_pkg::sfr_result_type      out_data
);

   logic                    valid_ff, valid_in;
   sfr_pkg::sfr_result_type data_ff;

   assign pop       = head_valid && (!valid_ff || !out_stall);
   assign valid_in  = pop || (valid_ff && out_stall);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) data_ff <= head_data;
   end

endmodule

`default_nettype wire

>>> hw/rtl/stuffed_frame_receiver_top.sv
// stuffed_frame_receiver_top: byte-stuffed frame receiver with xor block check
// depends on sfr_pkg, sfr_front, sfr_queue, sfr_back
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    rx_byte
//   rsp      out        rsp_valid/stall    kind, payload_byte, frame_seq, payload_length
//   csr      in         csr_valid/ready    index, data
//
// one byte per cycle while req_stall is low; a result passes the queue and the output register before it shows on rsp
// the parser classifies each byte as it is accepted, a 4-entry queue feeds the output register
// req_stall rises only while the queue is full
// synchronous reset restores register defaults and starts the flag hunt
`default_nettype none

module stuffed_frame_receiver_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_rx_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [1:0]                            rsp_kind,
   output logic [7:0]                            rsp_payload_byte,
   output logic                                  rsp_frame_seq,
   output logic [sfr_pkg::LEN_W-1:0]             rsp_payload_length,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [sfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [7:0]                       csr_data
);

   logic                    q_full, accept, res_valid, head_valid, pop;
   sfr_pkg::sfr_result_type res, head_data, out_data;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign csr_ready = 1'b1;

   sfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .byte_data  (req_rx_byte),
      .csr_we     (csr_valid && csr_ready),
      .csr_idx    (csr_index),
      .csr_wdata  (csr_data),
      .res_valid  (res_valid),
      .res        (res)
   );

   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   sfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .out_stall  (rsp_stall),
      .out_valid  (rsp_valid),
      .out_data   (out_data)
   );

   assign rsp_kind           = out_data.kind;
   assign rsp_payload_byte   = out_data.payload_byte;
   assign rsp_frame_seq      = out_data.frame_seq;
   assign rsp_payload_length = out_data.payload_length;

endmodule

`default_nettype wire

>>> hw/rtl/sfr_checker.sv
// sfr_checker: port-level assertions on the receiver's result channel
// depends on sfr_pkg and stuffed_frame_receiver_top (bound below)
`default_nettype none

module sfr_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [1:0]                   rsp_kind,
   input wire logic [7:0]                   rsp_payload_byte,
   input wire logic [sfr_pkg::LEN_W-1:0]    rsp_payload_length
);

   // stalled transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_payload_length))
      else $error("stalled rsp transaction changed");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sfr_pkg::KIND_PAYLOAD |-> rsp_payload_length == '0)
      else $error("payload transaction carries a length");

   a_verdict_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != sfr_pkg::KIND_PAYLOAD |-> rsp_payload_byte == 8'd0)
      else $error("verdict transaction carries a byte");

   a_long_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sfr_pkg::KIND_LONG |-> rsp_payload_length == '0)
      else $error("overlong transaction carries a length");

endmodule

bind stuffed_frame_receiver_top sfr_checker u_sfr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_payload_length (rsp_payload_length)
);

`default_nettype wire

>>> tb/stuffed_frame_receiver_top_tb.sv
// stuffed_frame_receiver_top_tb: self-checking bench for the stuffed frame receiver
// sends byte-stuffed frames under several register settings and checks every result
// depends on sfr_pkg and stuffed_frame_receiver_top
`default_nettype none

module stuffed_frame_receiver_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 3000;

   localparam logic [0:24][7:0] WARMUP_BYTES = {
      8'h00, 8'h7E, 8'h7E, 8'h03, 8'h00, 8'h03, 8'hFF, 8'h7D, 8'h5E, 8'h7D,
      8'h5D, 8'h7D, 8'h7E, 8'h00, 8'hA2, 8'h7E, 8'h7E, 8'h03, 8'h7E, 8'h03,
      8'h7E, 8'h03, 8'h80, 8'h83, 8'h7E
   };

   localparam logic [2:0] SEEK_FLAG = 3'd0;
   localparam logic [2:0] SEEK_ADDR = 3'd1;
   localparam logic [2:0] SEEK_CTRL = 3'd2;
   localparam logic [2:0] SEEK_HCHK = 3'd3;
   localparam logic [2:0] IN_DATA   = 3'd4;
   localparam logic [2:0] IN_ESC    = 3'd5;

   typedef enum int {
      FAULT_NONE, FAULT_ADDR, FAULT_CTRL, FAULT_HCHK, FAULT_CHECK, FAULT_EMPTY,
      FAULT_OPEN, FAULT_RAW
   } frame_fault_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic rsp_frame_seq;
   logic [sfr_pkg::LEN_W-1:0] rsp_payload_length;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sfr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0] csr_data = 8'h00;

   // register copy, indexed by register code
   logic [0:5][7:0] cfg = {8'd126, 8'd125, 8'd32, 8'd3, 8'd0, 8'd128};

   logic [2:0] rx_phase = SEEK_FLAG;
   logic expected_seq = 1'b0;
   logic [7:0] held_byte = 8'h00;
   logic held_valid = 1'b0;
   int data_count = 0;
   logic [7:0] data_xor = 8'h00;

   logic [7:0] line_bytes [$];
   sfr_pkg::sfr_result_type rx_outcomes_due [$];
   int bytes_queued = 0;
   int bytes_taken = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   logic gen_seq = 1'b0;

   int req_gap = 0;
   int req_stretch = 0;
   logic req_calm = 1'b0;
   int rsp_hold = 0;
   int rsp_stretch = 0;
   logic rsp_calm = 1'b0;

   stuffed_frame_receiver_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_seq      (rsp_frame_seq),
      .rsp_payload_length (rsp_payload_length),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void note_outcome(input logic [1:0] kind, input logic [7:0] data,
                                        input int len);
      sfr_pkg::sfr_result_type r;
      r.kind           = kind;
      r.payload_byte   = data;
      r.frame_seq      = expected_seq;
      r.payload_length = sfr_pkg::LEN_W'(len);
      rx_outcomes_due.push_back(r);
   endfunction

   function automatic void absorb_byte(input logic [7:0] d);
      if (data_count >= sfr_pkg::MAX_BYTES + 1) begin
         note_outcome(sfr_pkg::KIND_LONG, 8'h00, 0);
         rx_phase   = SEEK_FLAG;
         held_valid = 1'b0;
      end else begin
         if (held_valid) note_outcome(sfr_pkg::KIND_PAYLOAD, held_byte, 0);
         held_byte  = d;
         held_valid = 1'b1;
         data_count++;
         data_xor   = data_xor ^ d;
      end
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      logic [7:0] ctrl;
      logic ok;
      ctrl = expected_seq ? cfg[sfr_pkg::CSR_CTRL1] : cfg[sfr_pkg::CSR_CTRL0];
      case (rx_phase)
         SEEK_FLAG: begin
            if (b == cfg[sfr_pkg::CSR_FLAG]) rx_phase = SEEK_ADDR;
         end
         SEEK_ADDR: begin
            if (b == cfg[sfr_pkg::CSR_ADDRESS]) rx_phase = SEEK_CTRL;
            else if (b != cfg[sfr_pkg::CSR_FLAG]) rx_phase = SEEK_FLAG;
         end
         SEEK_CTRL: begin
            rx_phase = (b == ctrl) ? SEEK_HCHK : SEEK_FLAG;
         end
         SEEK_HCHK: begin
            if (b == (cfg[sfr_pkg::CSR_ADDRESS] ^ ctrl)) begin
               rx_phase   = IN_DATA;
               held_valid = 1'b0;
               held_byte  = 8'h00;
               data_count = 0;
               data_xor   = 8'h00;
            end else begin
               rx_phase = SEEK_FLAG;
            end
         end
         IN_DATA: begin
            if (b == cfg[sfr_pkg::CSR_FLAG]) begin
               ok = (data_count != 0) && (data_xor == 8'h00);
               note_outcome(ok ? sfr_pkg::KIND_ACCEPT : sfr_pkg::KIND_REJECT, 8'h00,
                            (data_count != 0) ? data_count - 1 : 0);
               if (ok) expected_seq = ~expected_seq;
               held_valid = 1'b0;
               rx_phase   = SEEK_FLAG;
            end else if (b == cfg[sfr_pkg::CSR_ESCAPE]) begin
               rx_phase = IN_ESC;
            end else begin
               absorb_byte(b);
            end
         end
         IN_ESC: begin
            rx_phase = IN_DATA;
            absorb_byte(b ^ cfg[sfr_pkg::CSR_MASK]);
         end
         default: begin
            rx_phase = SEEK_FLAG;
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] nonzero_byte();
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic void push_item(input logic [7:0] b);
      line_bytes.push_back(b);
      bytes_queued++;
   endfunction

   function automatic void stuff_byte(input logic [7:0] d);
      if (cfg[sfr_pkg::CSR_FLAG] != cfg[sfr_pkg::CSR_ESCAPE] &&
          (d == cfg[sfr_pkg::CSR_FLAG] || d == cfg[sfr_pkg::CSR_ESCAPE] ||
           $urandom_range(0, 15) == 0)) begin
         push_item(cfg[sfr_pkg::CSR_ESCAPE]);
         push_item(d ^ cfg[sfr_pkg::CSR_MASK]);
      end else begin
         push_item(d);
      end
   endfunction

   function automatic void queue_frame(input int n_data, input frame_fault_type fault);
      logic [7:0] ctrl;
      logic [7:0] addr;
      logic [7:0] sum;
      logic [7:0] d;
      int i;
      ctrl = gen_seq ? cfg[sfr_pkg::CSR_CTRL1] : cfg[sfr_pkg::CSR_CTRL0];
      addr = cfg[sfr_pkg::CSR_ADDRESS];
      sum  = 8'h00;
      if ($urandom_range(0, 4) == 0) push_item(cfg[sfr_pkg::CSR_FLAG]);
      push_item(cfg[sfr_pkg::CSR_FLAG]);
      push_item(fault == FAULT_ADDR ? addr ^ nonzero_byte() : addr);
      push_item(fault == FAULT_CTRL ? ctrl ^ nonzero_byte() : ctrl);
      push_item(fault == FAULT_HCHK ? addr ^ ctrl ^ nonzero_byte() : addr ^ ctrl);
      if (fault != FAULT_EMPTY) begin
         for (i = 0; i < n_data; i++) begin
            d = 8'($urandom);
            if (fault == FAULT_RAW && i == n_data / 2)
               push_item($urandom_range(0, 1) ? cfg[sfr_pkg::CSR_FLAG]
                                              : cfg[sfr_pkg::CSR_ESCAPE]);
            stuff_byte(d);
            sum = sum ^ d;
         end
         stuff_byte(fault == FAULT_CHECK ? sum ^ nonzero_byte() : sum);
      end
      if (fault != FAULT_OPEN) push_item(cfg[sfr_pkg::CSR_FLAG]);
      if (fault == FAULT_NONE) gen_seq = ~gen_seq;
   endfunction

   function automatic void queue_traffic(input int n_items);
      int stop;
      int r;
      int n_data;
      frame_fault_type fault;
      stop = bytes_queued + n_items;
      while (bytes_queued < stop) begin
         r = $urandom_range(0, 99);
         if (r < 70) n_data = $urandom_range(0, 8);
         else if (r < 95) n_data = $urandom_range(9, 40);
         else n_data = $urandom_range(41, 120);
         r = $urandom_range(0, 99);
         if (r < 64) fault = FAULT_NONE;
         else if (r < 69) fault = FAULT_ADDR;
         else if (r < 74) fault = FAULT_CTRL;
         else if (r < 79) fault = FAULT_HCHK;
         else if (r < 87) fault = FAULT_CHECK;
         else if (r < 91) fault = FAULT_EMPTY;
         else if (r < 95) fault = FAULT_OPEN;
         else fault = FAULT_RAW;
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) push_item(8'($urandom));
         end
         queue_frame(n_data, fault);
      end
   endfunction

   task automatic write_csr(input logic [sfr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx <= sfr_pkg::CSR_CTRL1) cfg[idx] = value;
   endtask

   task automatic apply_setting(input logic [7:0] flag, input logic [7:0] esc,
                                input logic [7:0] mask, input logic [7:0] addr,
                                input logic [7:0] ctrl0, input logic [7:0] ctrl1);
      write_csr(sfr_pkg::CSR_FLAG, flag);
      write_csr(sfr_pkg::CSR_ESCAPE, esc);
      write_csr(sfr_pkg::CSR_MASK, mask);
      write_csr(sfr_pkg::CSR_ADDRESS, addr);
      write_csr(sfr_pkg::CSR_CTRL0, ctrl0);
      write_csr(sfr_pkg::CSR_CTRL1, ctrl1);
      // unused indexes must leave every register alone
      write_csr(sfr_pkg::CSR_IDX_W'($urandom_range(int'(sfr_pkg::CSR_CTRL1) + 1,
                                                   (1 << sfr_pkg::CSR_IDX_W) - 1)),
                8'($urandom));
      gen_seq = expected_seq;
   endtask

   task automatic wait_quiet();
      while (bytes_taken != bytes_queued || rx_outcomes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : byte_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (req_stretch == 0) begin
               req_stretch = $urandom_range(50, 400);
               req_calm    = ($urandom_range(0, 3) == 0);
            end else begin
               req_stretch--;
            end
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (line_bytes.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= line_bytes.pop_front();
               if (!req_calm && $urandom_range(0, 3) == 0) req_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_backpressure
      if (rsp_stretch == 0) begin
         rsp_stretch = $urandom_range(50, 400);
         rsp_calm    = ($urandom_range(0, 3) == 0);
      end else begin
         rsp_stretch--;
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!rsp_calm && $urandom_range(0, 3) == 0) rsp_hold = pick_gap();
      end
   end

   always @(posedge clock) begin : result_monitor
      sfr_pkg::sfr_result_type want;
      sfr_pkg::sfr_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_kind, rsp_payload_byte, rsp_frame_seq, rsp_payload_length};
         if (rx_outcomes_due.size() == 0) begin
            if (mismatches < 50)
               $display("%0t: expected nothing, actual kind %0d byte %h seq %0d len %0d",
                        $time, got.kind, got.payload_byte, got.frame_seq,
                        got.payload_length);
            mismatches++;
         end else begin
            want = rx_outcomes_due.pop_front();
            if (got !== want) begin
               if (mismatches < 50)
                  $display({"%0t: expected kind %0d byte %h seq %0d len %0d,",
                            " actual kind %0d byte %h seq %0d len %0d"},
                           $time, want.kind, want.payload_byte, want.frame_seq,
                           want.payload_length, got.kind, got.payload_byte,
                           got.frame_seq, got.payload_length);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int i;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: repeated flag, stuffing, escape before flag, bad control, empty frame
      for (i = 0; i < 25; i++) push_item(WARMUP_BYTES[i]);
      queue_traffic(150);
      wait_quiet();

      apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
      queue_traffic(170);
      wait_quiet();

      apply_setting(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
      queue_traffic(170);
      wait_quiet();

      // address equal to flag, no-op stuff mask
      apply_setting(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF);
      queue_traffic(170);
      wait_quiet();

      // flag equal to escape, same control byte for both sequence bits
      apply_setting(8'h55, 8'h55, 8'h01, 8'hAA, 8'h10, 8'h10);
      queue_traffic(170);
      wait_quiet();

      // overlong frame: the last data byte fills the limit, the check byte overflows it
      apply_setting(8'h7E, 8'h7D, 8'h20, 8'h03, 8'h00, 8'h80);
      queue_frame(sfr_pkg::MAX_BYTES + 1, FAULT_CHECK);
      queue_traffic(60);
      wait_quiet();

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
